// File: rtl/udec_pkg.sv
package udec_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 6;
    localparam int PLACES   = 10;
    localparam int PLACE_W  = 4;
    localparam int WIDE_W   = 34;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [PLACE_W-1:0] t_place;
    typedef logic [WIDE_W-1:0]  t_wide;

    // Multiples of each power of ten: [place][digit], digit 0 to 9.
    typedef t_wide [PLACES-1:0][PLACES-1:0] t_mult_tab;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_place             top;
    } t_queue_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic t_mult_tab build_mult_tab();
        t_mult_tab tab;
        t_wide     pw;
        pw = t_wide'(1);
        for (int k = 0; k < PLACES; k++) begin
            for (int j = 0; j < PLACES; j++) begin
                tab[k][j] = t_wide'(pw * t_wide'(j));
            end
            pw = t_wide'(pw * t_wide'(10));
        end
        return tab;
    endfunction

    localparam t_mult_tab MULT_TAB = build_mult_tab();

endpackage

// File: rtl/udec_value_if.sv
interface udec_value_if;
    import udec_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/udec_digit_if.sv
interface udec_digit_if;
    import udec_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// File: rtl/udec_front.sv
module udec_front (
    udec_value_if.sink              i_in,
    input  udec_pkg::t_queue_status i_status,
    output logic                    o_push,
    output udec_pkg::t_queue_entry  o_entry
);
    import udec_pkg::*;

    logic [PLACES-1:1] ge;
    t_place            top;

    // Count powers of ten from 10 up at or below the value: index of the leading digit.
    always_comb begin
        top = '0;
        for (int k = 1; k < PLACES; k++) begin
            ge[k] = ({2'b00, i_in.value} >= MULT_TAB[k][1]);
            top   = top + t_place'(ge[k]);
        end
    end

    assign i_in.ready    = !i_status.full;
    assign o_push        = i_in.valid && !i_status.full;
    assign o_entry.value = i_in.value;
    assign o_entry.top   = top;
endmodule

// File: rtl/udec_queue.sv
module udec_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  udec_pkg::t_queue_entry  i_entry,
    input  logic                    i_pop,
    output udec_pkg::t_queue_entry  o_entry,
    output udec_pkg::t_queue_status o_status
);
    import udec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_queue_entry     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_entry        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end
endmodule

// File: rtl/udec_back.sv
module udec_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  udec_pkg::t_queue_entry  i_entry,
    input  udec_pkg::t_queue_status i_status,
    output logic                    o_pop,
    udec_digit_if.source            o_out
);
    import udec_pkg::*;

    logic [VALUE_W-1:0] r_rest, n_rest;
    t_place             r_place, n_place;
    logic               r_busy, n_busy;
    logic               r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;

    logic [PLACES-1:1]  ge;
    t_place             digit;
    logic               adv, take_new;

    // Digit at the current place: count of multiples of the place at or below the rest.
    always_comb begin
        digit = '0;
        for (int j = 1; j < PLACES; j++) begin
            ge[j] = ({2'b00, r_rest} >= MULT_TAB[r_place][j]);
            digit = digit + t_place'(ge[j]);
        end
    end

    assign adv      = r_busy && (!r_ovalid || o_out.ready);
    assign take_new = !r_busy || (adv && (r_place == '0));
    assign o_pop    = take_new && !i_status.empty;

    always_comb begin
        n_rest   = r_rest;
        n_place  = r_place;
        n_busy   = r_busy;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;
        if (adv) begin
            n_ovalid = 1'b1;
            n_char   = ASCII_ZERO + CHAR_W'(digit);
            n_last   = (r_place == '0);
            n_rest   = r_rest - MULT_TAB[r_place][digit][VALUE_W-1:0];
            n_place  = r_place - t_place'(1);
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
        if (take_new) begin
            n_busy = !i_status.empty;
            if (!i_status.empty) begin
                n_rest  = i_entry.value;
                n_place = i_entry.top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_place <= n_place;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.digit_char = r_char;
    assign o_out.last       = r_last;
endmodule

// File: rtl/uint_to_decimal_ascii_core.sv
// A value taken on an idle block passes the value queue and the back end's place registers
// before its first character shows. Throughput: one character per cycle while the output is
// ready, n characters for n digits (1 to 10); the back end does one place per cycle.
// Input is taken back to back while the value queue has room, even with a result stalled.
// Reset (i_rst_n low, synchronous) empties the queue and drops any value in progress.
module uint_to_decimal_ascii_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    udec_value_if.sink   i_in,
    udec_digit_if.source o_out
);
    import udec_pkg::*;

    // Front end: find the leading place of each value as it is transferred in.
    // The back end then starts at that place and never meets a leading zero.
    logic          push;
    logic          pop;
    t_queue_entry  push_entry;
    t_queue_entry  head_entry;
    t_queue_status status;

    udec_front u_front (
        .i_in     (i_in),
        .i_status (status),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Short queue of classified values: lets the input keep flowing while
    // the back end is still emitting the characters of an earlier value.
    udec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (status)
    );

    // Back end: one decimal place per cycle, subtracting the digit's multiple
    // of the place; hold the character in the output register while stalled,
    // and pull the next value from the queue on the cycle the last digit advances.
    udec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head_entry),
        .i_status (status),
        .o_pop    (pop),
        .o_out    (o_out)
    );
endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import udec_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 16;
    localparam int FREEZE_CYCLES = 60;
    localparam int FREEZE_ITEMS  = 30;
    localparam int PHASE_ITEMS   = 120;

    localparam logic [VALUE_W-1:0] TOP_SCALE = 32'd1_000_000_000;
    localparam logic [VALUE_W-1:0] RADIX     = 32'd10;

    // One expected character, tagged with the number it belongs to.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CHAR_W-1:0]  digit_char;
        logic               last;
    } t_char_exp;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               send_valid = 1'b0;
    logic [VALUE_W-1:0] send_value = '0;
    logic               take_ready = 1'b0;

    // Set when a value is on offer and cleared when it transfers.
    bit                 offer_busy;
    bit                 freeze_req;
    bit                 rx_frozen;
    int unsigned        send_idle_pct;
    int unsigned        take_idle_pct;

    logic [VALUE_W-1:0] value_pend_q[$];
    t_char_exp          char_exp_q[$];

    int                 values_done;
    int                 chars_done;
    int                 fault_cnt;
    int                 cycle_cnt;
    bit [10:1]          lengths_seen;

    udec_value_if num_bus ();
    udec_digit_if char_bus ();

    assign num_bus.valid  = send_valid;
    assign num_bus.value  = send_value;
    assign char_bus.ready = take_ready;

    uint_to_decimal_ascii_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_bus),
        .o_out   (char_bus)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Work out the characters that one number turns into and queue them up.
    function automatic void predict_chars(input logic [VALUE_W-1:0] num);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] scale;
        logic [VALUE_W-1:0] digit;
        bit                 leading;
        int                 n;
        t_char_exp          ent;
        rest    = num;
        scale   = TOP_SCALE;
        leading = 1'b1;
        n       = 0;
        // Walk the places from billions down to tens; drop zeros ahead of the
        // first non-zero digit, keep every zero after it.
        while (scale >= RADIX) begin
            digit = rest / scale;
            rest  = rest % scale;
            scale = scale / RADIX;
            if (!leading || digit != '0) begin
                leading = 1'b0;
                ent = '{value: num, digit_char: ASCII_ZERO + CHAR_W'(digit), last: 1'b0};
                char_exp_q.push_back(ent);
                n++;
            end
        end
        // The units digit always goes out, so zero still prints as one character,
        // and it closes the number.
        ent = '{value: num, digit_char: ASCII_ZERO + CHAR_W'(rest), last: 1'b1};
        char_exp_q.push_back(ent);
        lengths_seen[n + 1] = 1'b1;
    endfunction

    // Draw a random number: some fully random, most by digit count so that
    // short numbers turn up as often as long ones, with the edges of each
    // length weighted up.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        int unsigned        ndig;
        if ($urandom_range(3) == 0) begin
            return $urandom();
        end
        ndig = $urandom_range(10, 1);
        lo   = 1;
        repeat (ndig - 1) lo = lo * RADIX;
        hi   = (ndig == 10) ? '1 : lo * RADIX - 1;
        if (ndig == 1) begin
            lo = '0;
        end
        case ($urandom_range(7))
            0: begin
                return lo;
            end
            1: begin
                return hi;
            end
            default: begin
                return $urandom_range(hi, lo);
            end
        endcase
    endfunction

    // Driver: hold an offered value until it transfers, then pick the next one
    // from the pending queue, idling at random between transfers.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            send_valid <= 1'b0;
        end else if (!offer_busy) begin
            if (value_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                send_value <= value_pend_q.pop_front();
                send_valid <= 1'b1;
                offer_busy = 1'b1;
            end else begin
                send_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or hold ready low for the whole of a freeze.
    always @(negedge i_clk) begin
        if (rx_frozen) begin
            take_ready <= 1'b0;
        end else begin
            take_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Long output freeze, counted on its own so the sender keeps pushing and
    // the block's input side backs up.
    always begin
        wait (freeze_req);
        @(posedge i_clk);
        rx_frozen = 1'b1;
        repeat (FREEZE_CYCLES) @(posedge i_clk);
        rx_frozen  = 1'b0;
        freeze_req = 1'b0;
    end

    // Monitor: predict on every input transfer, check every output transfer
    // against the oldest expected character.
    always @(posedge i_clk) begin
        t_char_exp want;
        if (i_rst_n) begin
            if (num_bus.valid && num_bus.ready) begin
                predict_chars(num_bus.value);
                offer_busy = 1'b0;
                values_done++;
            end
            if (char_bus.valid && char_bus.ready) begin
                if (char_exp_q.size() == 0) begin
                    $display("%0t: unexpected char %0d last %0b, nothing expected",
                             $time, char_bus.digit_char, char_bus.last);
                    fault_cnt++;
                end else begin
                    want = char_exp_q.pop_front();
                    chars_done++;
                    if (char_bus.digit_char !== want.digit_char) begin
                        $display("%0t: value %0d: expected char %0d, got %0d",
                                 $time, want.value, want.digit_char, char_bus.digit_char);
                        fault_cnt++;
                    end
                    if (char_bus.last !== want.last) begin
                        $display("%0t: value %0d: expected last %0b, got %0b",
                                 $time, want.value, want.last, char_bus.last);
                        fault_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: run stuck, %0d characters still expected", $time, char_exp_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic feed_random(input int count);
        repeat (count) value_pend_q.push_back(pick_value());
    endtask

    // Wait until every value has transferred and every
    // character has come back.
    task automatic drain();
        while (value_pend_q.size() != 0 || offer_busy || char_exp_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        // Zero, the widest value, powers of ten and their neighbours, inner and
        // trailing zeros, and alternating bit patterns.
        logic [VALUE_W-1:0] corner_vals [20] = '{
            32'd0,          32'd1,          32'd9,          32'd10,
            32'd11,         32'd99,         32'd100,        32'd101,
            32'd999999999,  32'd1000000000, 32'd1000000001, 32'd4294967295,
            32'd4294967294, 32'd2147483647, 32'd2147483648, 32'd1234567890,
            32'd100000,     32'h55555555,   32'hAAAAAAAA,   32'd4000000009
        };

        send_idle_pct = 15;
        take_idle_pct = 67;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Busy sender, heavily stalled receiver.
        foreach (corner_vals[k]) value_pend_q.push_back(corner_vals[k]);
        feed_random(PHASE_ITEMS);
        drain();

        // Swap: busy receiver, sparse sender.
        send_idle_pct = 67;
        take_idle_pct = 15;
        feed_random(PHASE_ITEMS);
        drain();

        // Back to back on both sides, opening with a long output freeze.
        send_idle_pct = 0;
        take_idle_pct = 0;
        freeze_req    = 1'b1;
        feed_random(FREEZE_ITEMS);
        drain();
        feed_random(PHASE_ITEMS - FREEZE_ITEMS);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Converted %0d values into %0d checked characters under three idle mixes",
                 values_done, chars_done);
        $display("Digit counts seen (bit n = n digits): %b, plus a %0d-cycle output freeze",
                 lengths_seen, FREEZE_CYCLES);
        if (fault_cnt == 0 && char_exp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
